// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers on clk_i (BMP_ASSERT also gated by rst_ni); empty when NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BMP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define BMP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("assertion failed");
`else
`define BMP_ASSERT(lbl, prop)
`define BMP_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ----- hdl/bmp24_pkg.sv -----
// ---------------------------------------------------------------------------
// BMP24 decoder package
// Shared types, codes and header constants of the BMP pixel decoder.
// ---------------------------------------------------------------------------
`default_nettype none
package bmp24_pkg;

  localparam int unsigned Q_DEPTH = 2;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_HEADER = 6'b000010,
    PH_SKIP   = 6'b000100,
    PH_PIXEL  = 6'b001000,
    PH_PAD    = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_e;

  typedef enum logic [2:0] {
    ST_PIXEL      = 3'd0,
    ST_BAD_SIG    = 3'd1,
    ST_BAD_DEPTH  = 3'd2,
    ST_BAD_SIZE   = 3'd3,
    ST_BAD_OFFSET = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    FMT_RGB565 = 2'd0,
    FMT_RGB888 = 2'd1,
    FMT_XRGB   = 2'd2
  } format_e;

  localparam logic [1:0] SLOT_BLUE  = 2'd0;
  localparam logic [1:0] SLOT_GREEN = 2'd1;
  localparam logic [1:0] SLOT_RED   = 2'd2;

  localparam logic [4:0] HDR_SIG_HI    = 5'd1;
  localparam logic [4:0] HDR_OFFSET_LO = 5'd10;
  localparam logic [4:0] HDR_OFFSET_HI = 5'd13;
  localparam logic [4:0] HDR_WIDTH_LO  = 5'd18;
  localparam logic [4:0] HDR_WIDTH_HI  = 5'd21;
  localparam logic [4:0] HDR_HEIGHT_LO = 5'd22;
  localparam logic [4:0] HDR_HEIGHT_HI = 5'd25;
  localparam logic [4:0] HDR_DEPTH_LO  = 5'd28;
  localparam logic [4:0] HDR_DEPTH_HI  = 5'd29;
  localparam logic [1:0] HDR_LANE_BASE = 2'd2;

  localparam logic [15:0] SIG_BM          = 16'h4D42;
  localparam logic [15:0] SRC_DEPTH_24    = 16'd24;
  localparam logic [31:0] MIN_DATA_OFFSET = 32'd54;

  typedef struct packed {
    status_e     status;
    logic [1:0]  slot;
    logic [7:0]  data;
    logic [11:0] row;
    logic [11:0] column;
    logic        last;
  } q_entry_t;

endpackage
`default_nettype wire

// ----- hdl/bmp24_front.sv -----
// ---------------------------------------------------------------------------
// BMP24 front end
// Parses the header, tracks position, row and column, and queues one entry
// for every pixel byte and every error.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module bmp24_front #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  accept_i,
  input  wire  [7:0]           file_byte_i,
  input  wire                  file_start_i,
  output logic                 push_o,
  output bmp24_pkg::q_entry_t  entry_o
);
  import bmp24_pkg::*;

  localparam int unsigned DIM_W  = $clog2(MAX_DIM + 1);
  localparam int unsigned CALC_W = (DIM_W > 12) ? DIM_W : 12;

  phase_e             phase_q, phase_d, phase;
  logic [31:0]        pos_q, pos_d, pos;
  logic [15:0]        sig_q, sig_d;
  logic [31:0]        off_q, off_d;
  logic [31:0]        wid_q, wid_d;
  logic [31:0]        hgt_q, hgt_d;
  logic [15:0]        dep_q, dep_d;
  logic [DIM_W-1:0]   row_q, row_d;
  logic [DIM_W-1:0]   col_q, col_d;
  logic [1:0]         slot_q, slot_d;
  logic [1:0]         pad_q, pad_d;

  logic               active;
  logic               do_pixel;
  logic [4:0]         hpos;
  logic [1:0]         lane;
  logic [15:0]        sig_full;
  logic [15:0]        dep_full;
  logic [DIM_W-1:0]   col_inc;
  logic [DIM_W-1:0]   row_inc;
  logic [CALC_W-1:0]  row_calc;
  logic [CALC_W-1:0]  col_ext;

  assign active = accept_i && (file_start_i || (phase_q != PH_IDLE && phase_q != PH_DONE));

  always_comb begin
    phase    = file_start_i ? PH_HEADER : phase_q;
    pos      = file_start_i ? '0 : pos_q;
    hpos     = pos[4:0];
    lane     = hpos[1:0] - HDR_LANE_BASE;
    sig_full = {file_byte_i, sig_q[7:0]};
    dep_full = {file_byte_i, dep_q[7:0]};
    col_inc  = col_q + 1'b1;
    row_inc  = row_q + 1'b1;
    row_calc = CALC_W'(hgt_q[DIM_W-1:0]) - 1'b1 - CALC_W'(row_q);
    col_ext  = CALC_W'(col_q);

    phase_d  = phase_q;
    pos_d    = pos_q;
    sig_d    = sig_q;
    off_d    = off_q;
    wid_d    = wid_q;
    hgt_d    = hgt_q;
    dep_d    = dep_q;
    row_d    = row_q;
    col_d    = col_q;
    slot_d   = slot_q;
    pad_d    = pad_q;
    do_pixel = 1'b0;
    push_o   = 1'b0;
    entry_o  = '0;

    if (active) begin
      if (file_start_i) begin
        sig_d  = '0;
        off_d  = '0;
        wid_d  = '0;
        hgt_d  = '0;
        dep_d  = '0;
        row_d  = '0;
        col_d  = '0;
        slot_d = SLOT_BLUE;
        pad_d  = '0;
        phase_d = PH_HEADER;
      end
      pos_d = pos + 1'b1;
      case (phase)
        PH_HEADER: begin
          if (hpos <= HDR_SIG_HI) begin
            sig_d[{hpos[0], 3'b000} +: 8] = file_byte_i;
            if (hpos == HDR_SIG_HI && sig_full != SIG_BM) begin
              push_o         = 1'b1;
              entry_o.status = ST_BAD_SIG;
              phase_d        = PH_DONE;
            end
          end else if (hpos >= HDR_OFFSET_LO && hpos <= HDR_OFFSET_HI) begin
            off_d[{lane, 3'b000} +: 8] = file_byte_i;
          end else if (hpos >= HDR_WIDTH_LO && hpos <= HDR_WIDTH_HI) begin
            wid_d[{lane, 3'b000} +: 8] = file_byte_i;
          end else if (hpos >= HDR_HEIGHT_LO && hpos <= HDR_HEIGHT_HI) begin
            hgt_d[{lane, 3'b000} +: 8] = file_byte_i;
          end else if (hpos >= HDR_DEPTH_LO && hpos <= HDR_DEPTH_HI) begin
            dep_d[{hpos[0], 3'b000} +: 8] = file_byte_i;
            if (hpos == HDR_DEPTH_HI) begin
              if (dep_full != SRC_DEPTH_24) begin
                push_o         = 1'b1;
                entry_o.status = ST_BAD_DEPTH;
                phase_d        = PH_DONE;
              end else if (wid_q == '0 || wid_q > 32'(MAX_DIM) ||
                           hgt_q == '0 || hgt_q > 32'(MAX_DIM)) begin
                push_o         = 1'b1;
                entry_o.status = ST_BAD_SIZE;
                phase_d        = PH_DONE;
              end else if (off_q < MIN_DATA_OFFSET) begin
                push_o         = 1'b1;
                entry_o.status = ST_BAD_OFFSET;
                phase_d        = PH_DONE;
              end else begin
                phase_d = PH_SKIP;
              end
            end
          end
        end
        PH_SKIP: begin
          if (pos == off_q) begin
            phase_d  = PH_PIXEL;
            do_pixel = 1'b1;
          end
        end
        PH_PAD: begin
          pad_d = pad_q - 1'b1;
          if (pad_q == 2'd1) begin
            phase_d = PH_PIXEL;
          end
        end
        PH_PIXEL: begin
          do_pixel = 1'b1;
        end
        default: begin
        end
      endcase

      if (do_pixel) begin
        push_o         = 1'b1;
        entry_o.status = ST_PIXEL;
        entry_o.slot   = slot_q;
        entry_o.data   = file_byte_i;
        entry_o.row    = row_calc[11:0];
        entry_o.column = col_ext[11:0];
        if (slot_q == SLOT_RED) begin
          slot_d = SLOT_BLUE;
          if (col_inc >= wid_q[DIM_W-1:0]) begin
            col_d = '0;
            row_d = row_inc;
            if (row_inc >= hgt_q[DIM_W-1:0]) begin
              entry_o.last = 1'b1;
              phase_d      = PH_DONE;
            end else begin
              pad_d = wid_q[1:0];
              if (wid_q[1:0] != 2'd0) begin
                phase_d = PH_PAD;
              end
            end
          end else begin
            col_d = col_inc;
          end
        end else begin
          slot_d = slot_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pos_q   <= '0;
      sig_q   <= '0;
      off_q   <= '0;
      wid_q   <= '0;
      hgt_q   <= '0;
      dep_q   <= '0;
      row_q   <= '0;
      col_q   <= '0;
      slot_q  <= SLOT_BLUE;
      pad_q   <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      sig_q   <= sig_d;
      off_q   <= off_d;
      wid_q   <= wid_d;
      hgt_q   <= hgt_d;
      dep_q   <= dep_d;
      row_q   <= row_d;
      col_q   <= col_d;
      slot_q  <= slot_d;
      pad_q   <= pad_d;
    end
  end

  `BMP_ASSERT(a_error_ends_parse, (push_o && entry_o.status != ST_PIXEL) |=> (phase_q == PH_DONE))
  `BMP_ASSERT(a_last_ends_parse, (push_o && entry_o.last) |=> (phase_q == PH_DONE))

endmodule
`default_nettype wire

// ----- hdl/bmp24_queue.sv -----
// ---------------------------------------------------------------------------
// BMP24 entry queue
// Short FIFO that decouples the front end from the pixel back end.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module bmp24_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  bmp24_pkg::q_entry_t  entry_i,
  output logic                 full_o,
  output logic                 valid_o,
  input  wire                  pop_i,
  output bmp24_pkg::q_entry_t  entry_o
);
  import bmp24_pkg::*;

  localparam int unsigned PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

  q_entry_t          mem_q [Q_DEPTH];
  logic [PTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0]  count_q, count_d;

  assign full_o  = (count_q == CNT_W'(Q_DEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_q];

  always_comb begin
    wr_d    = wr_q;
    rd_d    = rd_q;
    count_d = count_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  `BMP_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(Q_DEPTH))
  `BMP_ASSERT(a_push_counts, (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1))

endmodule
`default_nettype wire

// ----- hdl/bmp24_back.sv -----
// ---------------------------------------------------------------------------
// BMP24 back end
// Gathers B,G,R bytes, converts the color and holds the result register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module bmp24_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire  [1:0]           cfg_wdata_i,
  input  wire                  q_valid_i,
  input  bmp24_pkg::q_entry_t  q_entry_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output logic [11:0]          pixel_row_o,
  output logic [11:0]          pixel_column_o,
  output logic [23:0]          pixel_color_o,
  output logic [2:0]           status_o,
  output logic                 last_pixel_o
);
  import bmp24_pkg::*;

  logic [1:0]   fmt_q;
  logic [7:0]   blue_q, green_q;
  logic         out_valid_q, out_valid_d;
  logic [11:0]  row_q, col_q;
  logic [23:0]  color_q, color_d;
  logic [2:0]   status_q;
  logic         last_q;
  logic         produces;
  logic         out_free;

  assign produces = (q_entry_i.status != ST_PIXEL) || (q_entry_i.slot == SLOT_RED);
  assign out_free = !out_valid_q || !out_stall_i;
  assign q_pop_o  = q_valid_i && (!produces || out_free);

  always_comb begin
    if (q_entry_i.status != ST_PIXEL) begin
      color_d = '0;
    end else if (fmt_q == FMT_RGB565) begin
      color_d = {8'h00, q_entry_i.data[7:3], green_q[7:2], blue_q[7:3]};
    end else begin
      color_d = {q_entry_i.data, green_q, blue_q};
    end
    out_valid_d = out_valid_q;
    if (q_pop_o && produces) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q       <= FMT_XRGB;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        fmt_q <= cfg_wdata_i;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_entry_i.status == ST_PIXEL) begin
      if (q_entry_i.slot == SLOT_BLUE) begin
        blue_q <= q_entry_i.data;
      end
      if (q_entry_i.slot == SLOT_GREEN) begin
        green_q <= q_entry_i.data;
      end
    end
    if (q_pop_o && produces) begin
      row_q    <= q_entry_i.row;
      col_q    <= q_entry_i.column;
      color_q  <= color_d;
      status_q <= q_entry_i.status;
      last_q   <= q_entry_i.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_row_o    = row_q;
  assign pixel_column_o = col_q;
  assign pixel_color_o  = color_q;
  assign status_o       = status_q;
  assign last_pixel_o   = last_q;

  `BMP_ASSERT(a_result_loaded, (q_pop_o && produces) |=> out_valid_q)

endmodule
`default_nettype wire

// ----- hdl/bmp24_stream_pixel_decoder.sv -----
// Path: an accepted byte is registered in the queue, then popped into the result register.
// Throughput: one byte per cycle; input stalls only while the two-entry
// queue is full.
// Reset: parse waits for a file start, queue and result register empty,
// dest_format returns to xRGB; no clearing pass is needed.
// ---------------------------------------------------------------------------
// BMP24 stream pixel decoder
// Byte-serial BMP 24 bpp parser with RGB565 / RGB888 / xRGB pixel output.
// ---------------------------------------------------------------------------
`default_nettype none
module bmp24_stream_pixel_decoder #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          cfg_we_i,
  input  wire  [1:0]   cfg_wdata_i,
  input  wire          in_valid_i,
  output logic         in_stall_o,
  input  wire  [7:0]   file_byte_i,
  input  wire          file_start_i,
  output logic         out_valid_o,
  input  wire          out_stall_i,
  output logic [11:0]  pixel_row_o,
  output logic [11:0]  pixel_column_o,
  output logic [23:0]  pixel_color_o,
  output logic [2:0]   status_o,
  output logic         last_pixel_o
);
  import bmp24_pkg::*;

  logic      q_full;
  logic      q_valid;
  logic      q_pop;
  logic      push;
  logic      accept;
  q_entry_t  push_entry;
  q_entry_t  head_entry;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  bmp24_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .file_byte_i  (file_byte_i),
    .file_start_i (file_start_i),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  bmp24_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .entry_o (head_entry)
  );

  bmp24_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .q_valid_i      (q_valid),
    .q_entry_i      (head_entry),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_row_o    (pixel_row_o),
    .pixel_column_o (pixel_column_o),
    .pixel_color_o  (pixel_color_o),
    .status_o       (status_o),
    .last_pixel_o   (last_pixel_o)
  );

endmodule
`default_nettype wire

// ----- sim/tb_bmp24_stream_pixel_decoder.sv -----
// ---------------------------------------------------------------------------
// BMP24 stream pixel decoder testbench
// Streams BMP files byte by byte into the decoder and checks every pixel and
// error result against a cycle-free predictor of the parser. Covers all
// destination formats, header errors, restarts, padding and the largest
// dimensions, with random idles and back-pressure on both channels.
// ---------------------------------------------------------------------------
module tb_bmp24_stream_pixel_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import bmp24_pkg::*;

  localparam int unsigned MAX_DIM     = 4096;
  localparam int unsigned CYCLE_LIMIT = 40000;

  typedef struct {
    logic [11:0] row;
    logic [11:0] column;
    logic [23:0] color;
    status_e     status;
    logic        last;
  } pixel_result_t;

  class pixel_scoreboard;
    pixel_result_t expected_q[$];
    int unsigned   mismatches = 0;
    logic [1:0]    format_q;
    phase_e        phase_q;
    logic [31:0]   pos_q, offset_q, width_q, height_q, file_row_q, column_q;
    logic [15:0]   sig_q, depth_q;
    logic [1:0]    slot_q, pad_q;
    logic [7:0]    blue_q, green_q;

    function void clear_parse();
      pos_q = '0; offset_q = '0; width_q = '0; height_q = '0;
      file_row_q = '0; column_q = '0; sig_q = '0; depth_q = '0;
      slot_q = SLOT_BLUE; pad_q = '0; blue_q = '0; green_q = '0;
    endfunction

    function void reset_state();
      clear_parse();
      format_q = FMT_XRGB;
      phase_q  = PH_IDLE;
      expected_q.delete();
    endfunction

    function void push_error(status_e code);
      pixel_result_t r;
      r.row = '0; r.column = '0; r.color = '0; r.status = code; r.last = 1'b0;
      expected_q.push_back(r);
      phase_q = PH_DONE;
    endfunction

    function void take_pixel_byte(logic [7:0] b);
      pixel_result_t r;
      if (slot_q == SLOT_BLUE) begin
        blue_q = b;
        slot_q = SLOT_GREEN;
        return;
      end
      if (slot_q == SLOT_GREEN) begin
        green_q = b;
        slot_q  = SLOT_RED;
        return;
      end
      slot_q = SLOT_BLUE;
      if (format_q == FMT_RGB565) begin
        r.color = {8'h00, b[7:3], green_q[7:2], blue_q[7:3]};
      end else begin
        r.color = {b, green_q, blue_q};
      end
      r.row    = 12'(height_q - 32'd1 - file_row_q);
      r.column = 12'(column_q);
      r.status = ST_PIXEL;
      r.last   = 1'b0;
      column_q++;
      if (column_q >= width_q) begin
        column_q = '0;
        file_row_q++;
        if (file_row_q >= height_q) begin
          r.last  = 1'b1;
          phase_q = PH_DONE;
        end else begin
          pad_q = 2'(32'd0 - width_q * 32'd3);
          if (pad_q != 2'd0) phase_q = PH_PAD;
        end
      end
      expected_q.push_back(r);
    endfunction

    function void note_byte(logic [7:0] b, logic s);
      logic [31:0] pos;
      if (s) begin
        clear_parse();
        phase_q = PH_HEADER;
      end else if (phase_q == PH_IDLE || phase_q == PH_DONE) begin
        return;
      end
      pos   = pos_q;
      pos_q = pos + 32'd1;
      case (phase_q)
        PH_HEADER: begin
          if (pos <= 32'(HDR_SIG_HI)) begin
            sig_q |= 16'(b) << (8 * pos);
            if (pos == 32'(HDR_SIG_HI) && sig_q != SIG_BM) push_error(ST_BAD_SIG);
          end else if (pos >= 32'(HDR_OFFSET_LO) && pos <= 32'(HDR_OFFSET_HI)) begin
            offset_q |= 32'(b) << (8 * (pos - 32'(HDR_OFFSET_LO)));
          end else if (pos >= 32'(HDR_WIDTH_LO) && pos <= 32'(HDR_WIDTH_HI)) begin
            width_q |= 32'(b) << (8 * (pos - 32'(HDR_WIDTH_LO)));
          end else if (pos >= 32'(HDR_HEIGHT_LO) && pos <= 32'(HDR_HEIGHT_HI)) begin
            height_q |= 32'(b) << (8 * (pos - 32'(HDR_HEIGHT_LO)));
          end else if (pos >= 32'(HDR_DEPTH_LO) && pos <= 32'(HDR_DEPTH_HI)) begin
            depth_q |= 16'(b) << (8 * (pos - 32'(HDR_DEPTH_LO)));
            if (pos == 32'(HDR_DEPTH_HI)) begin
              if (depth_q != SRC_DEPTH_24) begin
                push_error(ST_BAD_DEPTH);
              end else if (width_q == 0 || width_q > MAX_DIM ||
                           height_q == 0 || height_q > MAX_DIM) begin
                push_error(ST_BAD_SIZE);
              end else if (offset_q < MIN_DATA_OFFSET) begin
                push_error(ST_BAD_OFFSET);
              end else begin
                phase_q = PH_SKIP;
              end
            end
          end
        end
        PH_SKIP: begin
          if (pos == offset_q) begin
            phase_q = PH_PIXEL;
            take_pixel_byte(b);
          end
        end
        PH_PAD: begin
          pad_q = pad_q - 2'd1;
          if (pad_q == 2'd0) phase_q = PH_PIXEL;
        end
        default: take_pixel_byte(b);
      endcase
    endfunction

    function void check_result(logic [11:0] row, logic [11:0] column, logic [23:0] color,
                               logic [2:0] status, logic last);
      pixel_result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: row %0d column %0d color %06h status %0d",
               row, column, color, status);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (row !== want.row) begin
        $error("pixel_row expected %0d actual %0d", want.row, row);
        mismatches++;
      end
      if (column !== want.column) begin
        $error("pixel_column expected %0d actual %0d", want.column, column);
        mismatches++;
      end
      if (color !== want.color) begin
        $error("pixel_color expected %06h actual %06h", want.color, color);
        mismatches++;
      end
      if (status !== want.status) begin
        $error("status expected %0d actual %0d", want.status, status);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last_pixel expected %0d actual %0d", want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  file_byte_i;
  logic        file_start_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [11:0] pixel_row_o;
  logic [11:0] pixel_column_o;
  logic [23:0] pixel_color_o;
  logic [2:0]  status_o;
  logic        last_pixel_o;

  pixel_scoreboard board = new();
  logic [7:0]      file_bytes[$];
  bit              steady_mode;
  bit              hold_pending;
  int unsigned     accepted_bytes;
  int unsigned     cycle_count;

  bmp24_stream_pixel_decoder #(
    .MAX_DIM(MAX_DIM)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .file_byte_i   (file_byte_i),
    .file_start_i  (file_start_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_row_o   (pixel_row_o),
    .pixel_column_o(pixel_column_o),
    .pixel_color_o (pixel_color_o),
    .status_o      (status_o),
    .last_pixel_o  (last_pixel_o)
  );

  always #6ns clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_result(pixel_row_o, pixel_column_o, pixel_color_o, status_o, last_pixel_o);
    end
  end

  initial begin : receiver
    int hold_left;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i = 1'b1;
      end else if (steady_mode) begin
        out_stall_i = 1'b0;
      end else begin
        out_stall_i = ($urandom_range(99) < 37);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic s);
    @(negedge clk_i);
    while (!steady_mode && $urandom_range(99) < 37) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    file_byte_i  = b;
    file_start_i = s;
    do @(posedge clk_i); while (in_stall_o);
    board.note_byte(b, s);
    accepted_bytes++;
  endtask

  task automatic send_file(input int count, input int hold_at);
    int total;
    total = (count < 0 || count > file_bytes.size()) ? file_bytes.size() : count;
    for (int i = 0; i < total; i++) begin
      if (i == hold_at) hold_pending = 1'b1;
      send_byte(file_bytes[i], i == 0);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_format(input logic [1:0] fmt);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = fmt;
    @(posedge clk_i);
    board.format_q = fmt;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic build_image(input logic [15:0] sig, input logic [31:0] w, input logic [31:0] h,
                             input logic [31:0] off, input logic [15:0] depth, input int fill);
    logic [7:0] hdr[54];
    bit         well_formed;
    int         pad;
    file_bytes.delete();
    foreach (hdr[i]) hdr[i] = 8'($urandom);
    hdr[0] = sig[7:0];
    hdr[1] = sig[15:8];
    for (int k = 0; k < 4; k++) begin
      hdr[HDR_OFFSET_LO + k] = off[8*k +: 8];
      hdr[HDR_WIDTH_LO + k]  = w[8*k +: 8];
      hdr[HDR_HEIGHT_LO + k] = h[8*k +: 8];
    end
    hdr[HDR_DEPTH_LO] = depth[7:0];
    hdr[HDR_DEPTH_HI] = depth[15:8];
    foreach (hdr[i]) file_bytes.push_back(hdr[i]);
    well_formed = sig == SIG_BM && depth == SRC_DEPTH_24 && w != 0 && w <= MAX_DIM &&
                  h != 0 && h <= MAX_DIM && off >= MIN_DATA_OFFSET;
    if (well_formed) begin
      while (file_bytes.size() < off) file_bytes.push_back(8'($urandom));
      pad = (4 - (int'(w) * 3) % 4) % 4;
      for (int r = 0; r < int'(h); r++) begin
        for (int c = 0; c < 3 * int'(w); c++) begin
          file_bytes.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
        end
        for (int p = 0; p < pad; p++) file_bytes.push_back(8'($urandom));
      end
    end
    repeat ($urandom_range(3)) file_bytes.push_back(8'($urandom));
  endtask

  initial begin : stimulus
    int unsigned random_start;
    int          iter;
    int          kind;
    logic [31:0] w, h;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    file_byte_i  = '0;
    file_start_i = 1'b0;
    steady_mode  = 1'b0;
    hold_pending = 1'b0;
    board.reset_state();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // bytes ahead of any file start are dropped
    for (int i = 0; i < 3; i++) send_byte(8'($urandom), 1'b0);

    // hold the receiver while pixels keep coming
    set_format(FMT_RGB565);
    build_image(SIG_BM, 3, 2, 56, SRC_DEPTH_24, -1);
    send_file(-1, 58);

    set_format(FMT_RGB888);
    build_image(SIG_BM, 3, 1, 54, SRC_DEPTH_24, 8'hFF);
    send_file(-1, -1);
    set_format(2'd3);
    build_image(SIG_BM, 1, 3, 60, SRC_DEPTH_24, -1);
    send_file(-1, -1);
    set_format(FMT_RGB565);
    build_image(SIG_BM, 2, 1, 54, SRC_DEPTH_24, 8'hFF);
    send_file(-1, -1);

    // header errors, including combinations that test the check order
    build_image(16'h4D58, 2, 2, 54, SRC_DEPTH_24, -1);    send_file(8, -1);
    build_image(16'h5842, 2, 2, 54, SRC_DEPTH_24, -1);    send_file(8, -1);
    build_image(SIG_BM, 2, 2, 54, 16'd32, -1);            send_file(31, -1);
    build_image(SIG_BM, 2, 2, 54, 16'h0118, -1);          send_file(31, -1);
    build_image(SIG_BM, 0, 2, 54, SRC_DEPTH_24, -1);      send_file(31, -1);
    build_image(SIG_BM, 2, 0, 54, SRC_DEPTH_24, -1);      send_file(31, -1);
    build_image(SIG_BM, 4097, 2, 54, SRC_DEPTH_24, -1);   send_file(31, -1);
    build_image(SIG_BM, 2, 32'hFFFF_FFFF, 54, SRC_DEPTH_24, -1);  send_file(31, -1);
    build_image(SIG_BM, 32'h8000_0000, 2, 54, SRC_DEPTH_24, -1);  send_file(31, -1);
    build_image(SIG_BM, 2, 2, 53, SRC_DEPTH_24, -1);      send_file(31, -1);
    build_image(SIG_BM, 0, 2, 54, 16'd8, -1);             send_file(31, -1);
    build_image(SIG_BM, 0, 2, 0, SRC_DEPTH_24, -1);       send_file(31, -1);

    // restart in the signature, the header, the skip and the pixel data
    build_image(SIG_BM, 4, 4, 64, SRC_DEPTH_24, -1);
    send_file(1, -1);
    send_file(20, -1);
    send_file(60, -1);
    send_file(70, -1);

    // largest dimensions, no idling; only the start of the pixel data is sent
    set_format(FMT_XRGB);
    steady_mode = 1'b1;
    build_image(SIG_BM, MAX_DIM, 1, 54, SRC_DEPTH_24, -1);
    send_file(78, -1);
    set_format(FMT_RGB565);
    build_image(SIG_BM, 1, MAX_DIM, 54, SRC_DEPTH_24, -1);
    send_file(78, -1);
    wait_drained();
    steady_mode = 1'b0;

    random_start = accepted_bytes;
    iter = 0;
    while (accepted_bytes - random_start < 70) begin
      steady_mode = (iter >= 6 && iter < 12);
      if ($urandom_range(3) == 0) set_format(2'($urandom_range(3)));
      kind = $urandom_range(99);
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 4);
      if (kind < 75) begin
        build_image(SIG_BM, w, h, $urandom_range(54, 64), SRC_DEPTH_24, -1);
        if (kind < 65) send_file(-1, -1);
        else send_file($urandom_range(1, file_bytes.size() - 1), -1);
      end else if (kind < 90) begin
        case ($urandom_range(3))
          0: build_image(16'($urandom), w, h, 54, SRC_DEPTH_24, -1);
          1: build_image(SIG_BM, w, h, 54, 16'($urandom_range(64)), -1);
          2: build_image(SIG_BM, ($urandom_range(1) != 0) ? 32'($urandom) | 32'h8000_0000 : 0,
                         h, 54, SRC_DEPTH_24, -1);
          default: build_image(SIG_BM, w, h, $urandom_range(53), SRC_DEPTH_24, -1);
        endcase
        send_file(-1, -1);
      end else begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom), $urandom_range(9) == 0);
      end
      iter++;
    end
    steady_mode = 1'b0;

    @(negedge clk_i);
    in_valid_i = 1'b0;
    for (int n = 0; n < 20000 && board.expected_q.size() != 0; n++) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (board.expected_q.size() != 0) begin
      $error("%0d expected results never arrived", board.expected_q.size());
      board.mismatches++;
    end
    if (board.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+hdl
hdl/bmp24_pkg.sv
hdl/bmp24_front.sv
hdl/bmp24_queue.sv
hdl/bmp24_back.sv
hdl/bmp24_stream_pixel_decoder.sv
sim/tb_bmp24_stream_pixel_decoder.sv
